// ===== rtl/core/tla_pkg.sv =====
// Shared types and constants for the two-link arm solver.
// No dependencies.
`timescale 1ns / 1ps

package tla_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int COS_FRAC_BITS_DEF = 14;
  localparam int LEN_W             = 14;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;

  // register indices
  localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER  = 2'd3;

  localparam logic [LEN_W-1:0] UPPER_RST = 14'd1600;
  localparam logic [LEN_W-1:0] LOWER_RST = 14'd1600;

  // beyond: past the full reach; near: closer than the length difference
  typedef struct packed {
    logic beyond;
    logic near;
  } flags_t;

endpackage

// ===== rtl/core/tla_stream_if.sv =====
// Valid/ready word channel carrying a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface tla_stream_if #(
  parameter int W = 32
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/tla_sqrt.sv =====
// Pipelined restoring integer square root, one result bit per stage.
// Depends on nothing; stall via shared enable.
`timescale 1ns / 1ps

module tla_sqrt #(
  parameter int IN_W  = 34,
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [IN_W-1:0]     rad,
  input  logic [TAG_W-1:0]    tag_in,
  output logic [(IN_W+1)/2-1:0] root,
  output logic [TAG_W-1:0]    tag_out
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int PW = 2 * RW;

  logic [PW-1:0]    rem_r  [RW+1];
  logic [RW-1:0]    q_r    [RW+1];
  logic [PW-1:0]    val_r  [RW+1];
  logic [TAG_W-1:0] tag_r  [RW+1];

  assign rem_r[0] = '0;
  assign q_r[0]   = '0;
  assign val_r[0] = PW'(rad);
  assign tag_r[0] = tag_in;

  // one bit per stage
  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [PW+1:0]    trial;
    logic [PW+1:0]    cur;
    logic [PW-1:0]    rem_nxt;
    logic [RW-1:0]    q_nxt;
    logic [PW-1:0]    rem_s_r;
    logic [RW-1:0]    q_s_r;
    logic [PW-1:0]    val_s_r;
    logic [TAG_W-1:0] tag_s_r;
    always_comb begin
      cur   = {rem_r[i], val_r[i][PW-1 -: 2]};
      trial = (PW+2)'({q_r[i], 2'b01});
      if (cur >= trial) begin
        rem_nxt = PW'(cur - trial);
        q_nxt   = {q_r[i][RW-2:0], 1'b1};
      end else begin
        rem_nxt = PW'(cur);
        q_nxt   = {q_r[i][RW-2:0], 1'b0};
      end
    end
    // tag holds the valid bit, so it is cleared on reset
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_s_r <= '0;
      end else if (en) begin
        rem_s_r <= rem_nxt;
        q_s_r   <= q_nxt;
        val_s_r <= {val_r[i][PW-3:0], 2'b00};
        tag_s_r <= tag_r[i];
      end
    end
    assign rem_r[i+1] = rem_s_r;
    assign q_r[i+1]   = q_s_r;
    assign val_r[i+1] = val_s_r;
    assign tag_r[i+1] = tag_s_r;
  end

  assign root    = q_r[RW];
  assign tag_out = tag_r[RW];
endmodule

// ===== rtl/core/tla_div.sv =====
// Pipelined unsigned restoring divider with round-to-nearest (ties up).
// One quotient bit per stage; stall via shared enable.
`timescale 1ns / 1ps

module tla_div #(
  parameter int NW    = 48,
  parameter int DW    = 32,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [NW-1:0]    num,
  input  logic [DW-1:0]    den,
  input  logic [TAG_W-1:0] tag_in,
  output logic [NW-1:0]    quo,
  output logic [TAG_W-1:0] tag_out
);
  logic [DW:0]      rem_s [NW+1];
  logic [NW-1:0]    q_s   [NW+1];
  logic [NW-1:0]    n_s   [NW+1];
  logic [DW-1:0]    d_s   [NW+1];
  logic [TAG_W-1:0] t_s   [NW+1];

  assign rem_s[0] = '0;
  assign q_s[0]   = '0;
  assign n_s[0]   = num;
  assign d_s[0]   = den;
  assign t_s[0]   = tag_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW+1:0] cur;
    logic [DW:0]   r_nxt;
    logic          b;
    logic [DW:0]   rr;
    logic [NW-1:0] qr;
    logic [NW-1:0] nr;
    logic [DW-1:0] dr;
    logic [TAG_W-1:0] tr;
    always_comb begin
      cur = {rem_s[i], n_s[i][NW-1]};
      b   = cur >= (DW+2)'(d_s[i]);
      r_nxt = b ? (DW+1)'(cur - (DW+2)'(d_s[i])) : (DW+1)'(cur);
    end
    // tag holds the valid bit, so it is cleared on reset
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tr <= '0;
      end else if (en) begin
        rr <= r_nxt;
        qr <= {q_s[i][NW-2:0], b};
        nr <= {n_s[i][NW-2:0], 1'b0};
        dr <= d_s[i];
        tr <= t_s[i];
      end
    end
    assign rem_s[i+1] = rr;
    assign q_s[i+1]   = qr;
    assign n_s[i+1]   = nr;
    assign d_s[i+1]   = dr;
    assign t_s[i+1]   = tr;
  end

  // round: add one where 2*rem >= den
  assign quo     = q_s[NW] + NW'({rem_s[NW], 1'b0} >= (DW+2)'(d_s[NW]));
  assign tag_out = t_s[NW];
endmodule

// ===== rtl/core/two_link_arm_solver.sv =====
// Two-link arm inverse kinematics solver: top level.
// Depends on tla_pkg, tla_stream_if, tla_sqrt, tla_div.
`timescale 1ns / 1ps

// Takes one target word per cycle while the output is not stalled and returns
// one word per target with the clamped tip, the elbow and two reach flags.
// There are 142 register stages: nine stages of arithmetic, a 17-stage
// distance root, a 51-stage cosine divider, a 16-stage sine root and a 49-stage
// divider bank for elbow and tip, the roots and dividers one bit per stage.
// The whole pipe advances only when the output register is free or being
// taken, so a stall holds every stage. Base and lengths must be written only
// while the pipe is empty.
module two_link_arm_solver #(
  parameter int COORD_WIDTH   = tla_pkg::COORD_WIDTH_DEF,
  parameter int COS_FRAC_BITS = tla_pkg::COS_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                           cfg_we,
  input  logic [tla_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tla_pkg::CFG_DATA_W-1:0] cfg_data,
  tla_stream_if.sink   in_ch,
  tla_stream_if.source out_ch
);
  localparam int CW  = COORD_WIDTH;
  localparam int FB  = COS_FRAC_BITS;
  localparam int LW  = tla_pkg::LEN_W;
  localparam int DXW = CW + 1;          // offset width
  localparam int D2W = 2 * DXW;         // squared distance
  localparam int DW  = DXW;             // distance
  localparam int NW  = D2W + FB + 3;    // cos numerator magnitude
  localparam int CNW = FB + 2;          // cos signed
  localparam int PW  = DXW + FB + 3;    // rotated product
  localparam int EW  = PW + LW + 1;     // elbow numerator
  localparam int TW  = DXW + LW + 2;    // tip numerator
  localparam int QW  = EW;
  localparam logic signed [CNW-1:0] ONE = CNW'(1) <<< FB;

  // ---------------- configuration ----------------
  logic signed [CW-1:0] base_x_r, base_y_r;
  logic [LW-1:0]        upper_r, lower_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= '0; base_y_r <= '0;
      upper_r  <= tla_pkg::UPPER_RST; lower_r <= tla_pkg::LOWER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tla_pkg::REG_BASE_X: base_x_r <= CW'(signed'(cfg_data));
        tla_pkg::REG_BASE_Y: base_y_r <= CW'(signed'(cfg_data));
        tla_pkg::REG_UPPER:  upper_r  <= cfg_data[LW-1:0];
        tla_pkg::REG_LOWER:  lower_r  <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable and output ----------------
  logic en;
  logic out_valid_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = rst_n && en;

  // payload carried through each unit as a tag
  typedef struct packed {
    logic                  v;
    logic signed [CW-1:0]  tx;
    logic signed [CW-1:0]  ty;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic [D2W-1:0]        d2;
    logic [DW-1:0]         d;
    tla_pkg::flags_t       fl;
    logic signed [CNW-1:0] c;
    logic signed [CNW-1:0] s;
    logic                  cneg;
    logic                  zero;
  } tag_t;
  localparam int TGW = $bits(tag_t);

  // stage A: offsets
  tag_t a_r, a_nxt;
  always_comb begin
    a_nxt    = '0;
    a_nxt.v  = in_ch.valid;
    a_nxt.tx = in_ch.data[2*CW-1:CW];
    a_nxt.ty = in_ch.data[CW-1:0];
    a_nxt.dx = DXW'(signed'(in_ch.data[2*CW-1:CW])) - DXW'(base_x_r);
    a_nxt.dy = DXW'(signed'(in_ch.data[CW-1:0])) - DXW'(base_y_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.v <= 1'b0;
    end else if (en) begin
      a_r <= a_nxt;
    end
  end

  // stage B: squares
  tag_t b_r;
  logic [D2W-1:0] sqx_r, sqy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.v <= 1'b0;
    end else if (en) begin
      b_r   <= a_r;
      sqx_r <= D2W'(a_r.dx * a_r.dx);
      sqy_r <= D2W'(a_r.dy * a_r.dy);
    end
  end

  // stage C: sum, flags
  tag_t c_r, c_nxt;
  logic [2*LW+1:0] sum2, dif2;
  logic [LW:0]     lsum;
  logic [D2W-1:0]  d2c;
  always_comb begin
    lsum = (LW+1)'(upper_r) + (LW+1)'(lower_r);
    sum2 = (2*LW+2)'(lsum * lsum);
    dif2 = (2*LW+2)'((upper_r - lower_r) * (upper_r - lower_r));
    d2c  = sqx_r + sqy_r;
    c_nxt           = b_r;
    c_nxt.d2        = d2c;
    c_nxt.fl.beyond = d2c > D2W'(sum2);
    c_nxt.fl.near   = (upper_r > lower_r) && (d2c < D2W'(dif2));
    c_nxt.zero      = d2c == '0;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.v <= 1'b0;
    end else if (en) begin
      c_r <= c_nxt;
    end
  end

  // distance root
  logic [DW-1:0] root_d;
  tag_t rt_o;
  tla_sqrt #(.IN_W(D2W), .TAG_W(TGW)) u_sqrt_d (
    .clk, .rst_n, .en, .rad(c_r.d2), .tag_in(c_r), .root(root_d), .tag_out(rt_o));

  // stage D: zero fix, cos numerator and denominator
  tag_t e_r;
  logic signed [NW-1:0] cnum_r;
  logic [DW+LW:0]       cden_r;
  logic signed [NW-1:0] cn;
  tag_t rt_f;
  always_comb begin
    rt_f = rt_o;
    rt_f.d = root_d;
    if (rt_o.zero) begin
      rt_f.dx = DXW'(1); rt_f.dy = '0; rt_f.d = DW'(1);
    end
    cn = NW'(upper_r * upper_r) + NW'(rt_o.d2) - NW'(lower_r * lower_r);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.v <= 1'b0;
    end else if (en) begin
      e_r    <= rt_f;
      cnum_r <= cn;
      cden_r <= (DW+LW+1)'({upper_r, 1'b0} * rt_f.d);
    end
  end

  // cos division on magnitude
  logic [NW-1:0]  cq;
  tag_t cd_o, e_t;
  always_comb begin
    e_t = e_r;
    e_t.cneg = cnum_r[NW-1];
  end
  logic [NW-1:0] cmag;
  assign cmag = cnum_r[NW-1] ? NW'(-cnum_r) : NW'(cnum_r);
  tla_div #(.NW(NW), .DW(DW+LW+1), .TAG_W(TGW)) u_div_c (
    .clk, .rst_n, .en, .num(NW'(cmag << FB)), .den(cden_r), .tag_in(e_t),
    .quo(cq), .tag_out(cd_o));

  // stage F: saturate cos, square for sin
  tag_t f_r, f_nxt;
  logic [2*CNW-1:0] s2_r;
  logic signed [CNW-1:0] cs;
  always_comb begin
    if (cd_o.fl.beyond || cd_o.fl.near || cd_o.zero)
      cs = ONE;
    else if (cq > NW'(ONE))
      cs = cd_o.cneg ? -ONE : ONE;
    else
      cs = cd_o.cneg ? -CNW'(cq) : CNW'(cq);
    f_nxt   = cd_o;
    f_nxt.c = cs;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r.v <= 1'b0;
    end else if (en) begin
      f_r  <= f_nxt;
      s2_r <= (2*CNW)'((ONE * ONE) - (cs * cs));
    end
  end

  // sine root
  logic [CNW-1:0] sr;
  tag_t sq_o;
  tla_sqrt #(.IN_W(2*CNW), .TAG_W(TGW)) u_sqrt_s (
    .clk, .rst_n, .en, .rad(s2_r), .tag_in(f_r), .root(sr), .tag_out(sq_o));

  // stage G: rotated products
  tag_t g_r, g_nxt;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r;
  logic signed [CNW-1:0] sv;
  assign sv = (sq_o.fl.beyond || sq_o.fl.near) ? '0 : signed'(sr);
  always_comb begin
    g_nxt   = sq_o;
    g_nxt.s = sv;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r.v <= 1'b0;
    end else if (en) begin
      g_r  <= g_nxt;
      pa_r <= PW'(sq_o.dx * sq_o.c); pb_r <= PW'(sq_o.dy * sv);
      pc_r <= PW'(sq_o.dx * sv);     pd_r <= PW'(sq_o.dy * sq_o.c);
    end
  end

  // stage H: combine
  tag_t h_r;
  logic signed [PW-1:0] rx_r, ry_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r.v <= 1'b0;
    end else if (en) begin
      h_r  <= g_r;
      rx_r <= pa_r - pb_r; ry_r <= pc_r + pd_r;
    end
  end

  // stage I: scale by lengths
  tag_t i_r;
  logic signed [EW-1:0] ex_r, ey_r;
  logic signed [TW-1:0] tnx_r, tny_r;
  logic [DW+FB-1:0]     eden_r;
  logic [LW:0]          ls;
  assign ls = (LW+1)'(upper_r) + (LW+1)'(lower_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r.v <= 1'b0;
    end else if (en) begin
      i_r    <= h_r;
      ex_r   <= EW'(rx_r * signed'({1'b0, upper_r}));
      ey_r   <= EW'(ry_r * signed'({1'b0, upper_r}));
      tnx_r  <= TW'(h_r.dx * signed'({1'b0, ls}));
      tny_r  <= TW'(h_r.dy * signed'({1'b0, ls}));
      eden_r <= (DW+FB)'(h_r.d) << FB;
    end
  end

  // four divisions in parallel, magnitudes; signs ride in a small tag
  typedef struct packed {
    tag_t t;
    logic sx, sy, stx, sty;
  } dtag_t;
  localparam int DTW = $bits(dtag_t);
  dtag_t di, do0, do1, do2, do3;
  logic [QW-1:0] qex, qey, qtx, qty;
  always_comb begin
    di.t = i_r; di.sx = ex_r[EW-1]; di.sy = ey_r[EW-1];
    di.stx = tnx_r[TW-1]; di.sty = tny_r[TW-1];
  end
  tla_div #(.NW(QW), .DW(DW+FB), .TAG_W(DTW)) u_div_ex (
    .clk, .rst_n, .en, .num(QW'(ex_r[EW-1] ? -ex_r : ex_r)), .den(eden_r),
    .tag_in(di), .quo(qex), .tag_out(do0));
  tla_div #(.NW(QW), .DW(DW+FB), .TAG_W(DTW)) u_div_ey (
    .clk, .rst_n, .en, .num(QW'(ey_r[EW-1] ? -ey_r : ey_r)), .den(eden_r),
    .tag_in(di), .quo(qey), .tag_out(do1));
  tla_div #(.NW(QW), .DW(DW+FB), .TAG_W(DTW)) u_div_tx (
    .clk, .rst_n, .en, .num(QW'(tnx_r[TW-1] ? -tnx_r : tnx_r)),
    .den((DW+FB)'(i_r.d)), .tag_in(di), .quo(qtx), .tag_out(do2));
  tla_div #(.NW(QW), .DW(DW+FB), .TAG_W(DTW)) u_div_ty (
    .clk, .rst_n, .en, .num(QW'(tny_r[TW-1] ? -tny_r : tny_r)),
    .den((DW+FB)'(i_r.d)), .tag_in(di), .quo(qty), .tag_out(do3));

  // final: add base, saturate, output register
  function automatic logic [CW-1:0] sat(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] hi, lo;
    hi = (QW+2)'((64'sd1 <<< (CW-1)) - 1);
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  logic signed [QW+1:0] vex, vey, vtx, vty;
  always_comb begin
    vex = (QW+2)'(base_x_r) + (do0.sx ? -(QW+2)'(qex) : (QW+2)'(qex));
    vey = (QW+2)'(base_y_r) + (do0.sy ? -(QW+2)'(qey) : (QW+2)'(qey));
    vtx = (QW+2)'(base_x_r) + (do0.stx ? -(QW+2)'(qtx) : (QW+2)'(qtx));
    vty = (QW+2)'(base_y_r) + (do0.sty ? -(QW+2)'(qty) : (QW+2)'(qty));
  end

  logic [4*CW+1:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= do0.t.v;
      out_data_r  <= {
        do0.t.fl.beyond ? sat(vtx) : do0.t.tx,
        do0.t.fl.beyond ? sat(vty) : do0.t.ty,
        sat(vex), sat(vey),
        do0.t.fl.beyond, do0.t.fl.near};
    end
  end
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // unused tag copies from parallel dividers
  logic unused_tags;
  assign unused_tags = ^{do1, do2, do3};
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking bench for the two-link arm solver: random and directed targets,
// with an in-bench prediction of tip, elbow and reach flags for each word.
// Depends on tla_pkg, tla_stream_if and two_link_arm_solver.
`timescale 1ns / 1ps

module testbench;

  localparam int    ONE_Q  = 1 << tla_pkg::COS_FRAC_BITS_DEF;
  localparam longint C_MAX = 32767;
  localparam longint C_MIN = -32768;

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
  } target_t;

  typedef struct packed {
    logic signed [15:0] tip_x;
    logic signed [15:0] tip_y;
    logic signed [15:0] elbow_x;
    logic signed [15:0] elbow_y;
    logic               beyond_reach;
    logic               inside_min;
  } pose_t;

  logic clk;
  logic rst_n;
  logic                           cfg_we;
  logic [tla_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [tla_pkg::CFG_DATA_W-1:0] cfg_data;

  tla_stream_if #(.W($bits(target_t))) tgt_ch ();
  tla_stream_if #(.W($bits(pose_t)))   pose_ch ();

  two_link_arm_solver u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (tgt_ch.sink),
    .out_ch   (pose_ch.source)
  );

  // bench copy of the arm registers
  longint arm_bx, arm_by, arm_l1, arm_l2;

  target_t pending_targets[$];
  pose_t   expected_poses[$];
  int      mismatches;
  bit      tgt_taken;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // divide, round half away from zero; den > 0
  function automatic longint round_div(longint n, longint den);
    longint mag, q;
    mag = (n < 0) ? -n : n;
    q   = (mag + den / 2) / den;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp_coord(longint v);
    if (v > C_MAX) v = C_MAX;
    if (v < C_MIN) v = C_MIN;
    return v[15:0];
  endfunction

  // inverse kinematics of one target
  function automatic pose_t solve_arm(target_t t);
    pose_t  p;
    longint tx, ty, dx, dy, d2, d, sum, c, s, ox, oy, den, num;
    bit     far_out, too_near;
    tx  = t.target_x;
    ty  = t.target_y;
    sum = arm_l1 + arm_l2;
    dx  = tx - arm_bx;
    dy  = ty - arm_by;
    d2  = dx * dx + dy * dy;
    d   = longint'(int_sqrt(d2));
    far_out  = d2 > sum * sum;
    too_near = (arm_l1 > arm_l2) && (d2 < (arm_l1 - arm_l2) * (arm_l1 - arm_l2));
    if (d2 == 0) begin
      dx = 1;
      dy = 0;
      d  = 1;
    end
    if (far_out || too_near) begin
      c = ONE_Q;
      s = 0;
    end else begin
      den = 2 * arm_l1 * d;
      if (den == 0 || d2 == 0) begin
        c = ONE_Q;
      end else begin
        num = arm_l1 * arm_l1 + d2 - arm_l2 * arm_l2;
        c = round_div(num * ONE_Q, den);
        if (c > ONE_Q) c = ONE_Q;
        if (c < -ONE_Q) c = -ONE_Q;
      end
      s = longint'(int_sqrt(ONE_Q * ONE_Q - c * c));
    end
    ox = round_div(arm_l1 * (dx * c - dy * s), d * ONE_Q);
    oy = round_div(arm_l1 * (dx * s + dy * c), d * ONE_Q);
    if (far_out) begin
      p.tip_x = clamp_coord(arm_bx + round_div(dx * sum, d));
      p.tip_y = clamp_coord(arm_by + round_div(dy * sum, d));
    end else begin
      p.tip_x = clamp_coord(tx);
      p.tip_y = clamp_coord(ty);
    end
    p.elbow_x      = clamp_coord(arm_bx + ox);
    p.elbow_y      = clamp_coord(arm_by + oy);
    p.beyond_reach = far_out;
    p.inside_min   = too_near;
    return p;
  endfunction

  // target driver: bursts with random gaps, holds a word until taken
  int burst_left, gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      tgt_ch.valid <= 1'b0;
      tgt_ch.data  <= '0;
      burst_left   <= 0;
      gap_left     <= 0;
    end else if (!tgt_ch.valid || tgt_taken) begin
      if (gap_left > 0) begin
        gap_left     <= gap_left - 1;
        tgt_ch.valid <= 1'b0;
      end else if (pending_targets.size() > 0) begin
        tgt_ch.valid <= 1'b1;
        tgt_ch.data  <= pending_targets.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tgt_ch.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: always ready, random, periodic or mostly stalled, by a randomly drawn mode
  int rx_cyc, rx_mode;
  always @(negedge clk) begin
    if (!rst_n) begin
      pose_ch.ready <= 1'b0;
      rx_cyc        <= 0;
      rx_mode       <= 0;
    end else begin
      rx_cyc <= rx_cyc + 1;
      if (rx_cyc % 64 == 63) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: pose_ch.ready <= 1'b1;
        1: pose_ch.ready <= $urandom_range(0, 1);
        2: pose_ch.ready <= (rx_cyc % 8) > 2;
        default: pose_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // monitor: predict on accepted targets, check accepted poses
  always @(posedge clk) begin
    pose_t got, want;
    tgt_taken <= rst_n && tgt_ch.valid && tgt_ch.ready;
    if (rst_n && tgt_ch.valid && tgt_ch.ready)
      expected_poses.push_back(solve_arm(target_t'(tgt_ch.data)));
    if (rst_n && pose_ch.valid && pose_ch.ready) begin
      got = pose_t'(pose_ch.data);
      if (expected_poses.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_poses.pop_front();
        if (got !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch tip %0d,%0d/%0d,%0d elbow %0d,%0d/%0d,%0d flags %b%b/%b%b",
                     want.tip_x, want.tip_y, got.tip_x, got.tip_y,
                     want.elbow_x, want.elbow_y, got.elbow_x, got.elbow_y,
                     want.beyond_reach, want.inside_min, got.beyond_reach, got.inside_min);
        end
      end
    end
  end

  task automatic write_reg(logic [tla_pkg::CFG_IDX_W-1:0] idx, longint val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[15:0];
    case (idx)
      tla_pkg::REG_BASE_X: arm_bx = longint'($signed(val[15:0]));
      tla_pkg::REG_BASE_Y: arm_by = longint'($signed(val[15:0]));
      tla_pkg::REG_UPPER:  arm_l1 = val[13:0];
      default:             arm_l2 = val[13:0];
    endcase
  endtask

  task automatic set_arm(longint bx, longint by, longint l1, longint l2);
    write_reg(tla_pkg::REG_BASE_X, bx);
    write_reg(tla_pkg::REG_BASE_Y, by);
    write_reg(tla_pkg::REG_UPPER, l1);
    write_reg(tla_pkg::REG_LOWER, l2);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_target(longint x, longint y);
    target_t t;
    t.target_x = x[15:0];
    t.target_y = y[15:0];
    pending_targets.push_back(t);
  endtask

  // random targets, mostly spread over and around the arm's reach
  task automatic add_random(int n);
    longint r, ang_x, ang_y, sum;
    sum = arm_l1 + arm_l2;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1: add_target($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
        2:    add_target(arm_bx, arm_by);
        default: begin
          r     = $urandom_range(0, sum + sum / 4 + 2);
          ang_x = longint'($urandom_range(0, 2000)) - 1000;
          ang_y = longint'($urandom_range(0, 2000)) - 1000;
          r     = (ang_x == 0 && ang_y == 0) ? 0 : r;
          add_target(arm_bx + (ang_x * r) / 1000, arm_by + (ang_y * r) / 1000);
        end
      endcase
    end
  endtask

  task automatic drain;
    wait (pending_targets.size() == 0 && !tgt_ch.valid && expected_poses.size() == 0);
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    tgt_ch.valid = 1'b0;
    tgt_ch.data  = '0;
    pose_ch.ready = 1'b0;
    mismatches   = 0;
    arm_bx = 0;
    arm_by = 0;
    arm_l1 = tla_pkg::UPPER_RST;
    arm_l2 = tla_pkg::LOWER_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset lengths, field extremes, zero distance, in/out of reach
    add_target(0, 0);
    add_target(32767, 32767);
    add_target(-32768, -32768);
    add_target(32767, -32768);
    add_target(-32768, 32767);
    add_target(3200, 0);
    add_target(0, -3200);
    add_target(3201, 0);
    add_target(1000, 1000);
    add_target(-1, 0);
    add_target(0, 1);
    add_target(-2000, 500);
    drain;

    // long upper arm: inside-min region and small distances
    set_arm(-500, 700, 3000, 800);
    add_target(-500, 700);
    add_target(-499, 700);
    add_target(1700, 700);
    add_target(2300, 700);
    add_target(-500, 4501);
    add_random(100);
    drain;

    // corner base with maximal lengths: saturation
    set_arm(-32768, 32767, 16383, 16383);
    add_target(32767, -32768);
    add_target(-32768, 32767);
    add_target(0, 0);
    add_random(100);
    drain;

    set_arm(32767, -32768, 1, 0);
    add_target(32767, -32768);
    add_target(32767, -32767);
    add_random(90);
    drain;

    set_arm(0, 0, 16383, 0);
    add_target(16383, 0);
    add_target(16384, 0);
    add_random(90);
    drain;

    repeat (3) begin
      set_arm($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
              $urandom_range(1, 16383), $urandom_range(0, 16383));
      add_random(40);
      drain;
      set_arm($urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
              $urandom_range(1, 3000), $urandom_range(0, 3000));
      add_random(50);
      drain;
    end

    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
